>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the checker modules of the project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> hdl/snfs_pkg.sv
// ----------------------------------------------------------------------------
// snfs_pkg
// Types, track codes and the decimal digit step of the frame sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package snfs_pkg;

  localparam logic [7:0] TRACK_PRELUDE = 8'h12;
  localparam logic [7:0] TRACK_DIGIT0  = 8'h04;
  localparam logic [7:0] TRACK_HUNDRED = 8'h0F;
  localparam logic [7:0] TRACK_TEN     = 8'h10;
  localparam logic [7:0] TRACK_UNIT    = 8'h11;
  localparam logic [7:0] TRACK_CLOSING = 8'h0E;
  localparam logic [7:0] FRAME_LEN     = 8'h05;
  localparam logic [7:0] FRAME_ARG1    = 8'h00;

  localparam int NUM_SLOTS = 10;
  localparam int SLOT_W    = $clog2(NUM_SLOTS);

  localparam logic [SLOT_W-1:0] SLOT_PRELUDE = SLOT_W'(0);
  localparam logic [SLOT_W-1:0] SLOT_H       = SLOT_W'(1);
  localparam logic [SLOT_W-1:0] SLOT_HUNDRED = SLOT_W'(2);
  localparam logic [SLOT_W-1:0] SLOT_T       = SLOT_W'(3);
  localparam logic [SLOT_W-1:0] SLOT_TEN     = SLOT_W'(4);
  localparam logic [SLOT_W-1:0] SLOT_U       = SLOT_W'(5);
  localparam logic [SLOT_W-1:0] SLOT_UNIT    = SLOT_W'(6);
  localparam logic [SLOT_W-1:0] SLOT_D1      = SLOT_W'(7);
  localparam logic [SLOT_W-1:0] SLOT_D2      = SLOT_W'(8);
  localparam logic [SLOT_W-1:0] SLOT_CLOSING = SLOT_W'(9);

  localparam logic [13:0] DIV_H  = 14'd10000;
  localparam logic [13:0] DIV_T  = 14'd1000;
  localparam logic [13:0] DIV_U  = 14'd100;
  localparam logic [13:0] DIV_D1 = 14'd10;

  typedef struct packed {
    logic [3:0] h;
    logic [3:0] t;
    logic [3:0] u;
    logic [3:0] d1;
    logic [3:0] d2;
  } digits_t;

  typedef struct packed {
    logic [3:0]  q;
    logic [15:0] rem;
  } digit_res_t;

  // One decimal digit by parallel compares against the nine multiples.
  function automatic digit_res_t digit_step(input logic [15:0] r, input logic [13:0] dvs);
    digit_res_t res;
    logic [17:0] lim;
    res.q   = '0;
    res.rem = r;
    for (int k = 1; k <= 9; k++) begin
      lim = 18'(k) * {4'b0, dvs};
      if ({2'b0, r} >= lim) begin
        res.q   = 4'(k);
        res.rem = 16'({2'b0, r} - lim);
      end
    end
    return res;
  endfunction

endpackage

>>> hdl/snfs_digit_pipe.sv
// ----------------------------------------------------------------------------
// snfs_digit_pipe
// Four-stage pipeline that splits the value into five decimal digits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module snfs_digit_pipe (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [15:0]         value_hundredths,
  output logic                dig_valid,
  input  logic                dig_take,
  output snfs_pkg::digits_t   dig
);
  import snfs_pkg::*;

  logic        v1, v2, v3, v4;
  logic        en1, en2, en3, en4;
  logic [3:0]  h1, h2, h3, h4;
  logic [3:0]  t2, t3, t4;
  logic [3:0]  u3, u4;
  logic [3:0]  d1_4, d2_4;
  logic [13:0] r1;
  logic [9:0]  r2;
  logic [6:0]  r3;
  digit_res_t  st1, st2, st3, st4;

  assign en4 = !v4 || dig_take;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign in_stall = !en1;

  always_comb begin
    st1 = digit_step(value_hundredths, DIV_H);
    st2 = digit_step({2'b0, r1}, DIV_T);
    st3 = digit_step({6'b0, r2}, DIV_U);
    st4 = digit_step({9'b0, r3}, DIV_D1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      h1 <= st1.q;
      r1 <= st1.rem[13:0];
    end
    if (en2) begin
      h2 <= h1;
      t2 <= st2.q;
      r2 <= st2.rem[9:0];
    end
    if (en3) begin
      h3 <= h2;
      t3 <= t2;
      u3 <= st3.q;
      r3 <= st3.rem[6:0];
    end
    if (en4) begin
      h4   <= h3;
      t4   <= t3;
      u4   <= u3;
      d1_4 <= st4.q;
      d2_4 <= st4.rem[3:0];
    end
  end

  assign dig_valid = v4;
  assign dig.h  = h4;
  assign dig.t  = t4;
  assign dig.u  = u4;
  assign dig.d1 = d1_4;
  assign dig.d2 = d2_4;

endmodule

>>> hdl/snfs_frame_ser.sv
// ----------------------------------------------------------------------------
// snfs_frame_ser
// Turns one set of digits into its frames, one frame per cycle while out_stall
// is low, through a registered output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module snfs_frame_ser (
  input  logic                clk,
  input  logic                rst,
  input  logic                dig_valid,
  output logic                dig_take,
  input  snfs_pkg::digits_t   dig,
  input  logic [7:0]          play_command,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          command_byte,
  output logic [7:0]          track_number,
  output logic [7:0]          check_byte,
  output logic                last_frame
);
  import snfs_pkg::*;

  logic [NUM_SLOTS-1:0] mask;
  logic [NUM_SLOTS-1:0] mask_next;
  logic [NUM_SLOTS-1:0] mask_left;
  logic [NUM_SLOTS-1:0] mask_new;
  digits_t              held;
  logic [SLOT_W-1:0]    pick;
  logic [7:0]           pick_track;
  logic                 out_adv;

  assign out_adv = !out_valid || !out_stall;

  always_comb begin
    pick = SLOT_PRELUDE;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (mask[i]) pick = SLOT_W'(i);
    end
  end

  always_comb begin
    case (pick)
      SLOT_PRELUDE: pick_track = TRACK_PRELUDE;
      SLOT_H:       pick_track = TRACK_DIGIT0 + {4'b0, held.h};
      SLOT_HUNDRED: pick_track = TRACK_HUNDRED;
      SLOT_T:       pick_track = TRACK_DIGIT0 + {4'b0, held.t};
      SLOT_TEN:     pick_track = TRACK_TEN;
      SLOT_U:       pick_track = TRACK_DIGIT0 + {4'b0, held.u};
      SLOT_UNIT:    pick_track = TRACK_UNIT;
      SLOT_D1:      pick_track = TRACK_DIGIT0 + {4'b0, held.d1};
      SLOT_D2:      pick_track = TRACK_DIGIT0 + {4'b0, held.d2};
      SLOT_CLOSING: pick_track = TRACK_CLOSING;
      default:      pick_track = TRACK_CLOSING;
    endcase
  end

  always_comb begin
    mask_new = '0;
    mask_new[SLOT_PRELUDE] = 1'b1;
    mask_new[SLOT_H]       = dig.h != 4'd0;
    mask_new[SLOT_HUNDRED] = dig.h != 4'd0;
    mask_new[SLOT_T]       = (dig.t != 4'd0) || (dig.h != 4'd0);
    mask_new[SLOT_TEN]     = dig.t != 4'd0;
    mask_new[SLOT_U]       = dig.u != 4'd0;
    mask_new[SLOT_UNIT]    = 1'b1;
    mask_new[SLOT_D1]      = dig.d1 != 4'd0;
    mask_new[SLOT_D2]      = dig.d2 != 4'd0;
    mask_new[SLOT_CLOSING] = 1'b1;
  end

  always_comb begin
    mask_left = mask;
    if (out_adv) mask_left[pick] = 1'b0;
    dig_take  = dig_valid && (mask_left == '0);
    mask_next = dig_take ? mask_new : mask_left;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask      <= '0;
      out_valid <= 1'b0;
    end else begin
      mask <= mask_next;
      if (out_adv) out_valid <= mask != '0;
    end
  end

  always_ff @(posedge clk) begin
    if (dig_take) held <= dig;
    if (out_adv && mask != '0) begin
      command_byte <= play_command;
      track_number <= pick_track;
      check_byte   <= FRAME_LEN ^ play_command ^ FRAME_ARG1 ^ pick_track;
      last_frame   <= pick == SLOT_CLOSING;
    end
  end

endmodule

>>> hdl/spoken_number_frame_sequencer.sv
// ----------------------------------------------------------------------------
// spoken_number_frame_sequencer
// The first frame of a value passes the digit pipeline, slot mask and output
// register. Throughput: one frame per cycle while the output is not stalled; a
// value gives 3 to 10 frames, set by the frame serializer's slot mask.
// Reset (synchronous, active high) empties the pipeline and clears the command.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spoken_number_frame_sequencer (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] value_hundredths,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  command_byte,
  output logic [7:0]  track_number,
  output logic [7:0]  check_byte,
  output logic        last_frame
);
  import snfs_pkg::*;

  logic [7:0] play_command;
  logic       dig_valid;
  logic       dig_take;
  digits_t    dig;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {24'd0, play_command};

  always_ff @(posedge clk) begin
    if (rst) begin
      play_command <= 8'd0;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      play_command <= pwdata[7:0];
    end
  end

  snfs_digit_pipe u_pipe (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .value_hundredths (value_hundredths),
    .dig_valid        (dig_valid),
    .dig_take         (dig_take),
    .dig              (dig)
  );

  snfs_frame_ser u_ser (
    .clk          (clk),
    .rst          (rst),
    .dig_valid    (dig_valid),
    .dig_take     (dig_take),
    .dig          (dig),
    .play_command (play_command),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .command_byte (command_byte),
    .track_number (track_number),
    .check_byte   (check_byte),
    .last_frame   (last_frame)
  );

endmodule

>>> hdl/snfs_checker.sv
// ----------------------------------------------------------------------------
// snfs_checker
// Port-level checks of the frame sequencer, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module snfs_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] command_byte,
  input logic [7:0] track_number,
  input logic [7:0] check_byte,
  input logic       last_frame
);
  import snfs_pkg::*;

  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(track_number) && $stable(last_frame))
  `ASSERT_IMPLY(a_check, clk, rst, out_valid, check_byte == (FRAME_LEN ^ command_byte ^ FRAME_ARG1 ^ track_number))
  `ASSERT_IMPLY(a_last_closing, clk, rst, out_valid && last_frame, track_number == TRACK_CLOSING)
  `ASSERT_IMPLY(a_closing_last, clk, rst, out_valid && track_number == TRACK_CLOSING, last_frame)

endmodule

bind spoken_number_frame_sequencer snfs_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .command_byte (command_byte),
  .track_number (track_number),
  .check_byte   (check_byte),
  .last_frame   (last_frame)
);
